// ===== src/gcsb_pkg.sv =====
package gcsb_pkg;

   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int ROW_W   = 26;
   localparam int IDX_W   = 39;
   localparam int WORD_W  = 64;
   localparam int BIT_W   = 6;
   localparam int COUNT_W = 13;
   localparam int REG_W   = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = 13'd16;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TEST   = 2'd2,
      CMD_BOX    = 2'd3
   } cmd_type;

   typedef enum logic [REG_W-1:0] {
      REG_DIM_X = 2'd0,
      REG_DIM_Y = 2'd1,
      REG_DIM_Z = 2'd2
   } reg_idx_type;

   typedef struct packed {
      cmd_type              command;
      logic [COORD_W-1:0]   cell_x;
      logic [COORD_W-1:0]   cell_y;
      logic [COORD_W-1:0]   cell_z;
      logic [COORD_W-1:0]   box_hi_x;
      logic [COORD_W-1:0]   box_hi_y;
      logic [COORD_W-1:0]   box_hi_z;
   } req_type;

   typedef struct packed {
      logic                 answer;
      logic [COUNT_W-1:0]   member_count;
      logic                 set_empty;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]     dim_x;
      logic [DIM_W-1:0]     dim_y;
      logic [DIM_W-1:0]     dim_z;
   } dims_type;

   typedef struct packed {
      logic                 ok;
      logic [IDX_W-1:0]     idx;
      logic [ROW_W-1:0]     dydz;
   } idx_res_type;

endpackage

// ===== src/gcsb_index.sv =====
module gcsb_index #(
   parameter int CELL_CAPACITY = 4096
) (
   input  logic                                clock,
   input  logic [gcsb_pkg::COORD_W-1:0]        x,
   input  logic [gcsb_pkg::COORD_W-1:0]        y,
   input  logic [gcsb_pkg::COORD_W-1:0]        z,
   input  gcsb_pkg::dims_type                  dims,
   output gcsb_pkg::idx_res_type               res
);

   localparam int ROW_W = gcsb_pkg::ROW_W;
   localparam int IDX_W = gcsb_pkg::IDX_W;
   localparam logic [IDX_W-1:0] CAP = IDX_W'(CELL_CAPACITY);

   logic [ROW_W-1:0]              row_ff, row_in;
   logic [ROW_W-1:0]              area_ff, area_in;
   logic [ROW_W-1:0]              dydz_ff, dydz_in;
   logic [gcsb_pkg::COORD_W-1:0]  z_ff;
   logic [gcsb_pkg::DIM_W-1:0]    dz_ff;

   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]              vol_ff, vol_in;
   logic [ROW_W-1:0]              dydz2_ff;

   always_comb begin
      row_in  = ROW_W'(x) * ROW_W'(dims.dim_y) + ROW_W'(y);
      area_in = ROW_W'(dims.dim_x) * ROW_W'(dims.dim_y);
      dydz_in = ROW_W'(dims.dim_y) * ROW_W'(dims.dim_z);
      idx_in  = IDX_W'(row_ff) * IDX_W'(dz_ff) + IDX_W'(z_ff);
      vol_in  = IDX_W'(area_ff) * IDX_W'(dz_ff);
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      area_ff  <= area_in;
      dydz_ff  <= dydz_in;
      z_ff     <= z;
      dz_ff    <= dims.dim_z;
      idx_ff   <= idx_in;
      vol_ff   <= vol_in;
      dydz2_ff <= dydz_ff;
   end

   assign res.ok   = (idx_ff < vol_ff) && (idx_ff < CAP);
   assign res.idx  = idx_ff;
   assign res.dydz = dydz2_ff;

endmodule

// ===== src/gcsb_ram.sv =====
module gcsb_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [gcsb_pkg::WORD_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [gcsb_pkg::WORD_W-1:0]   rd_data
);

   logic [gcsb_pkg::WORD_W-1:0] words_ff [DEPTH];
   logic [gcsb_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= words_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/grid_cell_set_bitmap.sv =====
// Occupancy bitmap over a 3-D grid with a running member count, one bit per cell in a
// single-port-read store of 64-bit words. After reset the store is swept clear, one word
// per cycle, over all ceil(CELL_CAPACITY/64) words (64 at the default) before the first
// command is taken; configuration writes are taken at any time. Add, remove and test
// go from transfer to result through the pipelined index multiply, the read and
// write-back of one word, and the load of the output register. The next command is
// taken only after the result is loaded, so a new command is never accepted while the
// last one is still in progress. A box query whose high corner is out of range, or whose
// box is empty, finishes at the index check, without walking the box. Any other box
// query walks the box one (x, y) row at a time and, for each row, reads every store word
// that the row's z span touches through the registered read port, checking each word
// before the next is read; it stops early at the first word that holds a clear cell. A
// finished result sits in the output register while the next command is transferred in.
module grid_cell_set_bitmap #(
   parameter int CELL_CAPACITY = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gcsb_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gcsb_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gcsb_pkg::REG_W-1:0]        csr_index,
   input  logic [gcsb_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int NWORDS  = (CELL_CAPACITY + 63) / 64;
   localparam int ADDR_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CNT_W   = $clog2(CELL_CAPACITY + 1);
   localparam int IDX_W   = gcsb_pkg::IDX_W;
   localparam int WORD_W  = gcsb_pkg::WORD_W;
   localparam int BIT_W   = gcsb_pkg::BIT_W;
   localparam int COUNT_W = gcsb_pkg::COUNT_W;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NWORDS - 1);
   localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(WORD_W - 1);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_CALC   = 9'b000000100,
      ST_CHECK  = 9'b000001000,
      ST_MODIFY = 9'b000010000,
      ST_BASE   = 9'b000100000,
      ST_ROW    = 9'b001000000,
      ST_WREAD  = 9'b010000000,
      ST_WCHECK = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   logic                          done_ff, done_in;
   gcsb_pkg::dims_type            dims_ff, dims_in;
   gcsb_pkg::req_type             item_ff, item_in;
   logic [ADDR_W-1:0]             clr_ff, clr_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          ans_ff, ans_in;
   logic [IDX_W-1:0]              cur_ff, cur_in;
   logic [IDX_W-1:0]              end_ff, end_in;
   logic [IDX_W-1:0]              base_ff, base_in;
   logic [IDX_W-1:0]              xbase_ff, xbase_in;
   logic [gcsb_pkg::ROW_W-1:0]    dydz_ff, dydz_in;
   logic [gcsb_pkg::COORD_W-1:0]  xc_ff, xc_in;
   logic [gcsb_pkg::COORD_W-1:0]  yc_ff, yc_in;
   logic [WORD_W-1:0]             mask_ff, mask_in;
   logic                          last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   gcsb_pkg::rsp_type             rsp_ff, rsp_in;

   logic [gcsb_pkg::COORD_W-1:0]  ix_x, ix_y, ix_z;
   gcsb_pkg::idx_res_type         ix_res;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [WORD_W-1:0]             wr_data;
   logic [ADDR_W-1:0]             rd_addr;
   logic [WORD_W-1:0]             rd_data;
   logic [WORD_W-1:0]             bit_mask;
   logic                          bit_was;
   logic [IDX_W-1:0]              xbase_next;
   logic [BIT_W-1:0]              hi_bit;
   logic [CNT_W+COUNT_W-1:0]      cnt_ext;

   // hi corner for box range check, the cell otherwise; low corner row base after transfer
   always_comb begin
      if (state_ff == ST_IDLE) begin
         if (req_payload.command == gcsb_pkg::CMD_BOX) begin
            ix_x = req_payload.box_hi_x;
            ix_y = req_payload.box_hi_y;
            ix_z = req_payload.box_hi_z;
         end else begin
            ix_x = req_payload.cell_x;
            ix_y = req_payload.cell_y;
            ix_z = req_payload.cell_z;
         end
      end else begin
         ix_x = item_ff.cell_x;
         ix_y = item_ff.cell_y;
         ix_z = '0;
      end
   end

   gcsb_index #(
      .CELL_CAPACITY(CELL_CAPACITY)
   ) u_index (
      .clock(clock),
      .x(ix_x),
      .y(ix_y),
      .z(ix_z),
      .dims(dims_ff),
      .res(ix_res)
   );

   gcsb_ram #(
      .DEPTH(NWORDS),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign bit_mask   = WORD_W'(1) << cur_ff[BIT_W-1:0];
   assign bit_was    = (rd_data & bit_mask) != '0;
   assign xbase_next = xbase_ff + IDX_W'(dydz_ff);
   assign hi_bit     = (cur_ff[IDX_W-1:BIT_W] == end_ff[IDX_W-1:BIT_W]) ?
                       end_ff[BIT_W-1:0] : TOP_BIT;
   assign cnt_ext    = (CNT_W + COUNT_W)'(cnt_ff);

   always_comb begin
      dims_in = dims_ff;
      if (csr_valid) begin
         case (csr_index)
            gcsb_pkg::REG_DIM_X: dims_in.dim_x = csr_wdata;
            gcsb_pkg::REG_DIM_Y: dims_in.dim_y = csr_wdata;
            gcsb_pkg::REG_DIM_Z: dims_in.dim_z = csr_wdata;
            default: dims_in = dims_ff;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      item_in   = item_ff;
      clr_in    = clr_ff;
      cnt_in    = cnt_ff;
      ans_in    = ans_ff;
      cur_in    = cur_ff;
      end_in    = end_ff;
      base_in   = base_ff;
      xbase_in  = xbase_ff;
      dydz_in   = dydz_ff;
      xc_in     = xc_ff;
      yc_in     = yc_ff;
      mask_in   = mask_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_addr   = cur_ff[ADDR_W+BIT_W-1:BIT_W];
      wr_data   = rd_data;
      rd_addr   = cur_ff[ADDR_W+BIT_W-1:BIT_W];

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!done_ff && req_valid) begin
               item_in  = req_payload;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cur_in  = ix_res.idx;
            rd_addr = ix_res.idx[ADDR_W+BIT_W-1:BIT_W];
            dydz_in = ix_res.dydz;
            if (!ix_res.ok) begin
               ans_in  = 1'b0;
               done_in = 1'b1;
            end else if (item_ff.command == gcsb_pkg::CMD_BOX) begin
               if (item_ff.cell_x > item_ff.box_hi_x || item_ff.cell_y > item_ff.box_hi_y ||
                   item_ff.cell_z > item_ff.box_hi_z) begin
                  ans_in  = 1'b1;
                  done_in = 1'b1;
               end else begin
                  state_in = ST_BASE;
               end
            end else begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            case (item_ff.command)
               gcsb_pkg::CMD_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | bit_mask;
                  ans_in  = 1'b1;
                  if (!bit_was) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               gcsb_pkg::CMD_REMOVE: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~bit_mask;
                  ans_in  = 1'b1;
                  if (bit_was) begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end
               default: begin
                  ans_in = bit_was;
               end
            endcase
            done_in = 1'b1;
         end
         ST_BASE: begin
            base_in  = ix_res.idx;
            xbase_in = ix_res.idx;
            xc_in    = item_ff.cell_x;
            yc_in    = item_ff.cell_y;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            cur_in   = base_ff + IDX_W'(item_ff.cell_z);
            end_in   = base_ff + IDX_W'(item_ff.box_hi_z);
            state_in = ST_WREAD;
         end
         ST_WREAD: begin
            mask_in  = ({WORD_W{1'b1}} << cur_ff[BIT_W-1:0]) &
                       ({WORD_W{1'b1}} >> (TOP_BIT - hi_bit));
            last_in  = cur_ff[IDX_W-1:BIT_W] == end_ff[IDX_W-1:BIT_W];
            state_in = ST_WCHECK;
         end
         ST_WCHECK: begin
            if ((mask_ff & ~rd_data) != '0) begin
               ans_in  = 1'b0;
               done_in = 1'b1;
            end else if (!last_ff) begin
               cur_in   = {cur_ff[IDX_W-1:BIT_W] + (IDX_W - BIT_W)'(1), {BIT_W{1'b0}}};
               state_in = ST_WREAD;
            end else if (yc_ff != item_ff.box_hi_y) begin
               yc_in    = yc_ff + gcsb_pkg::COORD_W'(1);
               base_in  = base_ff + IDX_W'(dims_ff.dim_z);
               state_in = ST_ROW;
            end else if (xc_ff != item_ff.box_hi_x) begin
               xc_in    = xc_ff + gcsb_pkg::COORD_W'(1);
               yc_in    = item_ff.cell_y;
               xbase_in = xbase_next;
               base_in  = xbase_next;
               state_in = ST_ROW;
            end else begin
               ans_in  = 1'b1;
               done_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // hold the result until the output register is free
      if (done_in) begin
         state_in = ST_IDLE;
      end
      if (state_ff == ST_IDLE && done_ff) begin
         done_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_IDLE && done_ff && !(rsp_valid_ff && rsp_stall)) begin
         rsp_valid_in        = 1'b1;
         rsp_in.answer       = ans_ff;
         rsp_in.member_count = cnt_ext[COUNT_W-1:0];
         rsp_in.set_empty    = cnt_ff == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dims_ff      <= '{dim_x: gcsb_pkg::DIM_RESET, dim_y: gcsb_pkg::DIM_RESET,
                           dim_z: gcsb_pkg::DIM_RESET};
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dims_ff      <= dims_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      ans_ff   <= ans_in;
      cur_ff   <= cur_in;
      end_ff   <= end_in;
      base_ff  <= base_in;
      xbase_ff <= xbase_in;
      dydz_ff  <= dydz_in;
      xc_ff    <= xc_in;
      yc_ff    <= yc_in;
      mask_ff  <= mask_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE) || done_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

// ===== dv/tb_grid_cell_set_bitmap.sv =====
module tb_grid_cell_set_bitmap;
   import gcsb_pkg::*;

   localparam int CAPACITY = 4096;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [REG_W-1:0]    csr_index   = '0;
   logic [DIM_W-1:0]    csr_wdata   = '0;

   bit                  occupancy [CAPACITY];
   int                  member_total = 0;
   longint unsigned     grid_x = 16;
   longint unsigned     grid_y = 16;
   longint unsigned     grid_z = 16;
   rsp_type             expected_rsp [$];
   int                  errors = 0;
   int                  burst_left = 0;
   int                  stall_left = 0;
   int                  stall_pct = 0;

   grid_cell_set_bitmap u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // Occupancy predictor

   function automatic longint unsigned lin_index(longint unsigned x, longint unsigned y,
                                                 longint unsigned z);
      return (x * grid_y + y) * grid_z + z;
   endfunction

   function automatic bit on_grid(longint unsigned v);
      return v < grid_x * grid_y * grid_z && v < CAPACITY;
   endfunction

   function automatic bit box_fully_set(req_type r);
      int unsigned xi, yi, zi;
      if (!on_grid(lin_index(r.box_hi_x, r.box_hi_y, r.box_hi_z)))
         return 1'b0;
      if (r.cell_x > r.box_hi_x || r.cell_y > r.box_hi_y || r.cell_z > r.box_hi_z)
         return 1'b1;
      for (xi = r.cell_x; xi <= r.box_hi_x; xi++)
         for (yi = r.cell_y; yi <= r.box_hi_y; yi++)
            for (zi = r.cell_z; zi <= r.box_hi_z; zi++)
               if (!occupancy[lin_index(xi, yi, zi)])
                  return 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type apply_cmd(req_type r);
      rsp_type         res;
      longint unsigned idx;
      bit              was_set;
      res = '0;
      if (r.command == CMD_BOX) begin
         res.answer = box_fully_set(r);
      end else begin
         idx = lin_index(r.cell_x, r.cell_y, r.cell_z);
         if (on_grid(idx)) begin
            was_set = occupancy[idx];
            case (r.command)
               CMD_ADD: begin
                  if (!was_set)
                     member_total++;
                  occupancy[idx] = 1'b1;
                  res.answer = 1'b1;
               end
               CMD_REMOVE: begin
                  if (was_set)
                     member_total--;
                  occupancy[idx] = 1'b0;
                  res.answer = 1'b1;
               end
               default: begin
                  res.answer = was_set;
               end
            endcase
         end
      end
      res.member_count = member_total[COUNT_W-1:0];
      res.set_empty = (member_total == 0);
      return res;
   endfunction

   function automatic req_type make_req(cmd_type cmd, int unsigned x, int unsigned y,
                                        int unsigned z, int unsigned hx, int unsigned hy,
                                        int unsigned hz);
      req_type r;
      r.command  = cmd;
      r.cell_x   = x[COORD_W-1:0];
      r.cell_y   = y[COORD_W-1:0];
      r.cell_z   = z[COORD_W-1:0];
      r.box_hi_x = hx[COORD_W-1:0];
      r.box_hi_y = hy[COORD_W-1:0];
      r.box_hi_z = hz[COORD_W-1:0];
      return r;
   endfunction

   function automatic int unsigned pick_coord(longint unsigned extent);
      if (extent == 0 || $urandom_range(0, 9) == 0)
         return $urandom_range(0, 4095);
      return $urandom_range(0, ((extent > 4096) ? 4096 : extent) - 1);
   endfunction

   function automatic int unsigned clip_coord(int unsigned v);
      return (v > 4095) ? 4095 : v;
   endfunction

   // Channel drivers

   task automatic send_cmd(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 4);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_payload = r;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(apply_cmd(r));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input reg_idx_type ri, input logic [DIM_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = ri;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      case (ri)
         REG_DIM_X: grid_x = val;
         REG_DIM_Y: grid_y = val;
         default:   grid_z = val;
      endcase
      @(negedge clock);
   endtask

   task automatic set_dims(input int unsigned ex, input int unsigned ey, input int unsigned ez);
      write_reg(REG_DIM_X, ex[DIM_W-1:0]);
      write_reg(REG_DIM_Y, ey[DIM_W-1:0]);
      write_reg(REG_DIM_Z, ez[DIM_W-1:0]);
      csr_valid = 1'b0;
   endtask

   // Random stimulus pieces

   task automatic send_fill_and_probe(output int n);
      int unsigned lx, ly, lz, hx, hy, hz, xi, yi, zi;
      lx = pick_coord(grid_x);
      ly = pick_coord(grid_y);
      lz = pick_coord(grid_z);
      hx = clip_coord(lx + $urandom_range(0, 1));
      hy = clip_coord(ly + $urandom_range(0, 1));
      hz = clip_coord(lz + $urandom_range(0, 4));
      n = 0;
      for (xi = lx; xi <= hx; xi++)
         for (yi = ly; yi <= hy; yi++)
            for (zi = lz; zi <= hz; zi++) begin
               send_cmd(make_req(CMD_ADD, xi, yi, zi, $urandom(), $urandom(), $urandom()));
               n++;
            end
      send_cmd(make_req(CMD_BOX, lx, ly, lz, hx, hy, hz));
      n++;
      if ($urandom_range(0, 1) == 0) begin
         send_cmd(make_req(CMD_REMOVE, $urandom_range(lx, hx), $urandom_range(ly, hy),
                           $urandom_range(lz, hz), 0, 0, 0));
         send_cmd(make_req(CMD_BOX, lx, ly, lz, hx, hy, hz));
         n += 2;
      end
   endtask

   task automatic send_noise();
      bit [95:0] raw;
      req_type   r;
      raw = {$urandom(), $urandom(), $urandom()};
      r = raw[$bits(req_type)-1:0];
      // hold box spans short so a dense set cannot stretch the walk
      if (r.command == CMD_BOX && r.cell_x <= r.box_hi_x && r.cell_y <= r.box_hi_y &&
          r.cell_z <= r.box_hi_z) begin
         r.box_hi_x = clip_coord(r.cell_x + (r.box_hi_x & 7));
         r.box_hi_y = clip_coord(r.cell_y + (r.box_hi_y & 7));
         r.box_hi_z = clip_coord(r.cell_z + (r.box_hi_z & 7));
      end
      send_cmd(r);
   endtask

   task automatic send_single(input int add_pct);
      int unsigned pick, x, y, z;
      cmd_type     cmd;
      pick = $urandom_range(0, 99);
      if (pick < add_pct)
         cmd = CMD_ADD;
      else if (pick < add_pct + 25)
         cmd = CMD_REMOVE;
      else if (pick < add_pct + 40)
         cmd = CMD_TEST;
      else
         cmd = CMD_BOX;
      x = pick_coord(grid_x);
      y = pick_coord(grid_y);
      z = pick_coord(grid_z);
      if (cmd != CMD_BOX) begin
         send_cmd(make_req(cmd, x, y, z, $urandom(), $urandom(), $urandom()));
      end else if ($urandom_range(0, 9) == 0) begin
         send_cmd(make_req(cmd, x, y, z, (x == 0) ? 0 : x - 1, y + 3, z + 3));
      end else begin
         send_cmd(make_req(cmd, x, y, z, clip_coord(x + $urandom_range(0, 3)),
                           clip_coord(y + $urandom_range(0, 3)),
                           clip_coord(z + $urandom_range(0, 3))));
      end
   endtask

   // Tests

   task automatic test_default_grid();
      send_cmd(make_req(CMD_TEST,   0, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    0, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    0, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    15, 15, 15, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    16, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    4095, 4095, 4095, 4095, 4095, 4095));
      send_cmd(make_req(CMD_ADD,    0, 20, 3, 0, 0, 0));
      send_cmd(make_req(CMD_TEST,   1, 4, 3, 4095, 4095, 4095));
      send_cmd(make_req(CMD_REMOVE, 0, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_REMOVE, 0, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_REMOVE, 4095, 4095, 4095, 0, 0, 0));
      send_cmd(make_req(CMD_BOX,    15, 15, 15, 15, 15, 15));
      send_cmd(make_req(CMD_BOX,    0, 0, 0, 16, 0, 0));
      send_cmd(make_req(CMD_BOX,    3, 0, 0, 2, 5, 5));
      send_cmd(make_req(CMD_BOX,    20, 0, 0, 16, 0, 0));
      send_cmd(make_req(CMD_ADD,    2, 3, 4, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    2, 3, 5, 0, 0, 0));
      send_cmd(make_req(CMD_BOX,    2, 3, 4, 2, 3, 5));
      send_cmd(make_req(CMD_BOX,    2, 3, 4, 2, 3, 6));
      send_cmd(make_req(CMD_BOX,    0, 0, 0, 15, 15, 15));
      drain();
   endtask

   task automatic test_zero_extent();
      int n, sent;
      set_dims(0, 16, 16);
      send_cmd(make_req(CMD_ADD,  0, 0, 0, 0, 0, 0));
      send_cmd(make_req(CMD_TEST, 15, 15, 15, 0, 0, 0));
      send_cmd(make_req(CMD_BOX,  0, 0, 0, 0, 0, 0));
      sent = 0;
      while (sent < 30) begin
         if ($urandom_range(0, 3) == 0) begin
            send_noise();
            n = 1;
         end else begin
            send_fill_and_probe(n);
         end
         sent += n;
      end
      drain();
   endtask

   task automatic test_dim_extremes();
      set_dims(4096, 4096, 4096);
      send_cmd(make_req(CMD_ADD,    0, 0, 4095, 0, 0, 0));
      send_cmd(make_req(CMD_ADD,    0, 1, 0, 0, 0, 0));
      send_cmd(make_req(CMD_TEST,   0, 0, 4095, 0, 0, 0));
      send_cmd(make_req(CMD_BOX,    0, 0, 4094, 0, 0, 4095));
      send_cmd(make_req(CMD_REMOVE, 0, 0, 4095, 0, 0, 0));
      drain();
      set_dims(1, 1, 4096);
      send_cmd(make_req(CMD_ADD, 0, 0, 62, 0, 0, 0));
      send_cmd(make_req(CMD_ADD, 0, 0, 63, 0, 0, 0));
      send_cmd(make_req(CMD_ADD, 0, 0, 64, 0, 0, 0));
      send_cmd(make_req(CMD_ADD, 0, 0, 65, 0, 0, 0));
      send_cmd(make_req(CMD_BOX, 0, 0, 62, 0, 0, 65));
      send_cmd(make_req(CMD_BOX, 0, 0, 61, 0, 0, 65));
      drain();
      set_dims(8191, 8191, 8191);
      send_cmd(make_req(CMD_ADD, 0, 0, 100, 0, 0, 0));
      send_cmd(make_req(CMD_ADD, 4095, 4095, 4095, 0, 0, 0));
      drain();
   endtask

   task automatic test_random_traffic(input int unsigned ex, input int unsigned ey,
                                      input int unsigned ez, input int n_items,
                                      input int add_pct);
      int n, sent, kind;
      set_dims(ex, ey, ez);
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            send_fill_and_probe(n);
         end else if (kind < 27) begin
            send_noise();
            n = 1;
         end else begin
            send_single(add_pct);
            n = 1;
         end
         sent += n;
      end
      drain();
   endtask

   // Result checker

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            if (errors < 50)
               $display("%0t: unexpected result answer=%0d count=%0d empty=%0d", $time,
                        rsp_payload.answer, rsp_payload.member_count, rsp_payload.set_empty);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_payload.answer !== want.answer ||
                rsp_payload.member_count !== want.member_count ||
                rsp_payload.set_empty !== want.set_empty) begin
               if (errors < 50)
                  $display("%0t: mismatch expected answer=%0d count=%0d empty=%0d, actual answer=%0d count=%0d empty=%0d",
                           $time, want.answer, want.member_count, want.set_empty,
                           rsp_payload.answer, rsp_payload.member_count,
                           rsp_payload.set_empty);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(10, 80);
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
      end
      stall_left--;
      rsp_stall = ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_grid();
      test_zero_extent();
      test_dim_extremes();
      test_random_traffic(16, 16, 16, 150, 40);
      test_random_traffic(2, 2, 2, 100, 15);
      test_random_traffic(1, 1, 4096, 120, 40);
      test_random_traffic(4096, 1, 1, 100, 40);
      test_random_traffic(5, 7, 9, 100, 35);
      test_random_traffic(13, 17, 19, 80, 40);
      test_random_traffic(4096, 4096, 4096, 60, 40);
      test_random_traffic(8191, 3, 1, 60, 40);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #30000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
